>>> rtl/ftc_pkg.sv
`default_nettype none
package ftc_pkg;
   localparam int MaxVertices = 256;
   localparam int MaxEdges    = 512;
   localparam int VtxW   = $clog2(MaxVertices);
   localparam int VcntW  = VtxW + 1;
   localparam int EdgeW  = $clog2(MaxEdges);
   localparam int EcntW  = 16;
   localparam logic [EcntW-1:0] EdgeSat = '1;
   localparam logic OpAdd  = 1'b0;
   localparam logic OpEval = 1'b1;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_CLEAR = 8'b00000010,
      ST_POP   = 8'b00000100,
      ST_RDV   = 8'b00001000,
      ST_EDGE  = 8'b00010000,
      ST_MARK  = 8'b00100000,
      ST_CHECK = 8'b01000000,
      ST_OUT   = 8'b10000000
   } state_type;
endpackage
`default_nettype wire

>>> rtl/ftc_ram.sv
`default_nettype none
module ftc_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire [$clog2(Depth)-1:0] wr_addr,
   input  wire [Width-1:0]         wr_data,
   input  wire [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]        rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

>>> rtl/free_tree_check_core.sv
// Channel | Direction | Transaction content
// req     | in        | tdata: operation, end_a, end_b; add edge or evaluate
// rsp     | out       | tdata: is_tree, reached_count, edge_total, bad_endpoint
// csr     | in        | wdata: vertex_count
// An add transaction counts the edge and stores it while fewer than 512 are stored.
// An evaluate first clears every mark of the visited memory, one mark per cycle.
// The walk then pops each reached vertex off the stack and scans every stored edge
// for it; an edge touching it marks and pushes its other end if not yet visited.
// The result waits in an output register; req is not ready until it is taken.
// Reset is synchronous and clears control state and counters.
`default_nettype none
module free_tree_check_core (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,   // operation[0], end_a[8:1], end_b[16:9]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // is_tree[0], reached_count[9:1],
                                    // edge_total[25:10], bad_endpoint[26]
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [8:0]  csr_wdata
);
   import ftc_pkg::*;

   state_type state_ff, state_in;
   logic [VcntW-1:0] nv_reg_ff;
   logic [EcntW-1:0] ecnt_ff, ecnt_in;
   logic             bad_ff, bad_in;
   logic [VcntW-1:0] reach_ff, reach_in;
   logic [VcntW-1:0] depth_ff, depth_in;
   logic [EdgeW:0]   eidx_ff, eidx_in;
   logic [VtxW:0]    clr_ff, clr_in;
   logic [VtxW-1:0]  cur_ff, cur_in;
   logic             tree_ff, tree_in;
   logic [VtxW-1:0]  cand_ff, cand_in;

   logic [VtxW-1:0]  in_a, in_b, ea, eb, sk_rd;
   logic             op;
   logic [VcntW-1:0] nv;
   logic [EdgeW:0]   stored;
   logic [EdgeW:0]   enext;
   logic             ewr, swr;
   logic [EdgeW-1:0] ewaddr, eraddr;
   logic [VtxW-1:0]  swaddr, srdaddr, swdata;
   logic [VtxW-1:0]  cand;
   logic             hit;
   logic             vis_wr, vis_wdata, vis_rd;
   logic [VtxW-1:0]  vis_waddr;

   assign op   = req_tdata[0];
   assign in_a = req_tdata[8:1];
   assign in_b = req_tdata[16:9];
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_tready = (state_ff == ST_IDLE);
   assign nv = (nv_reg_ff > VcntW'(MaxVertices)) ? VcntW'(MaxVertices) : nv_reg_ff;
   assign stored = (ecnt_ff < EcntW'(MaxEdges)) ? ecnt_ff[EdgeW:0] : (EdgeW+1)'(MaxEdges);
   assign enext = eidx_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         nv_reg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         nv_reg_ff <= csr_wdata;
      end
   end

   ftc_ram #(.Width(VtxW), .Depth(MaxEdges)) u_ea (
      .clock(clock), .wr_en(ewr), .wr_addr(ewaddr), .wr_data(in_a),
      .rd_addr(eraddr), .rd_data(ea));
   ftc_ram #(.Width(VtxW), .Depth(MaxEdges)) u_eb (
      .clock(clock), .wr_en(ewr), .wr_addr(ewaddr), .wr_data(in_b),
      .rd_addr(eraddr), .rd_data(eb));
   ftc_ram #(.Width(VtxW), .Depth(MaxVertices)) u_stack (
      .clock(clock), .wr_en(swr), .wr_addr(swaddr), .wr_data(swdata),
      .rd_addr(srdaddr), .rd_data(sk_rd));
   ftc_ram #(.Width(1), .Depth(MaxVertices)) u_vis (
      .clock(clock), .wr_en(vis_wr), .wr_addr(vis_waddr), .wr_data(vis_wdata),
      .rd_addr(cand), .rd_data(vis_rd));

   assign ewaddr = ecnt_ff[EdgeW-1:0];
   assign ewr = (state_ff == ST_IDLE) && req_tvalid && (op == OpAdd)
                && (ecnt_ff < EcntW'(MaxEdges));
   // The edge read follows the next index, so ea and eb always match eidx_ff.
   assign eraddr = eidx_in[EdgeW-1:0];
   assign srdaddr = depth_ff[VtxW-1:0] - 1'b1;

   always_comb begin
      state_in = state_ff;
      ecnt_in = ecnt_ff;
      bad_in = bad_ff;
      reach_in = reach_ff;
      depth_in = depth_ff;
      eidx_in = eidx_ff;
      clr_in = clr_ff;
      cur_in = cur_ff;
      tree_in = tree_ff;
      cand_in = cand_ff;
      swr = 1'b0;
      swaddr = depth_ff[VtxW-1:0];
      swdata = cand_ff;
      vis_wr = 1'b0;
      vis_waddr = cand_ff;
      vis_wdata = 1'b1;
      cand = '0;
      hit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (op == OpAdd) begin
                  if ({1'b0, in_a} >= nv_reg_ff || {1'b0, in_b} >= nv_reg_ff) begin
                     bad_in = 1'b1;
                  end
                  if (ecnt_ff != EdgeSat) begin
                     ecnt_in = ecnt_ff + 1'b1;
                  end
               end else begin
                  clr_in = '0;
                  state_in = ST_CLEAR;
               end
            end
         end
         ST_CLEAR: begin
            // Vertex 0 is marked as the walk's start while the marks are cleared, if nv is nonzero.
            vis_wr = 1'b1;
            vis_waddr = clr_ff[VtxW-1:0];
            vis_wdata = (clr_ff == '0) && (nv != '0);
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (VtxW+1)'(MaxVertices - 1)) begin
               depth_in = '0;
               reach_in = '0;
               if (nv != '0) begin
                  reach_in = VcntW'(1);
                  swaddr = '0;
                  swdata = '0;
                  swr = 1'b1;
                  depth_in = VcntW'(1);
                  state_in = ST_POP;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_POP: begin
            if (depth_ff == '0) begin
               state_in = ST_CHECK;
            end else begin
               depth_in = depth_ff - 1'b1;
               eidx_in = '0;
               state_in = ST_RDV;
            end
         end
         ST_RDV: begin
            cur_in = sk_rd;
            if (stored != '0) begin
               state_in = ST_EDGE;
            end else begin
               state_in = ST_POP;
            end
         end
         ST_EDGE: begin
            if ({1'b0, ea} < nv && {1'b0, eb} < nv) begin
               if (ea == cur_ff) begin
                  cand = eb;
                  hit = 1'b1;
               end else if (eb == cur_ff) begin
                  cand = ea;
                  hit = 1'b1;
               end
            end
            cand_in = cand;
            if (hit) begin
               state_in = ST_MARK;
            end else begin
               eidx_in = enext;
               if (enext >= stored) begin
                  state_in = ST_POP;
               end
            end
         end
         ST_MARK: begin
            if (!vis_rd) begin
               vis_wr = 1'b1;
               reach_in = reach_ff + 1'b1;
               swr = 1'b1;
               depth_in = depth_ff + 1'b1;
            end
            eidx_in = enext;
            if (enext >= stored) begin
               state_in = ST_POP;
            end else begin
               state_in = ST_EDGE;
            end
         end
         ST_CHECK: begin
            tree_in = (nv != '0) && !bad_ff && (ecnt_ff <= EcntW'(MaxEdges))
                      && (ecnt_ff == EcntW'(nv - 1'b1)) && (reach_ff == nv);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               ecnt_in = '0;
               bad_in = 1'b0;
               reach_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ecnt_ff <= '0;
         bad_ff <= 1'b0;
         reach_ff <= '0;
         depth_ff <= '0;
         eidx_ff <= '0;
      end else begin
         state_ff <= state_in;
         ecnt_ff <= ecnt_in;
         bad_ff <= bad_in;
         reach_ff <= reach_in;
         depth_ff <= depth_in;
         eidx_ff <= eidx_in;
      end
   end

   always_ff @(posedge clock) begin
      clr_ff <= clr_in;
      cur_ff <= cur_in;
      tree_ff <= tree_in;
      cand_ff <= cand_in;
   end

   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata = {5'b0, bad_ff, ecnt_ff, reach_ff, tree_ff};
endmodule
`default_nettype wire

>>> tb/free_tree_check_core_test.sv
`default_nettype none
module free_tree_check_core_test;
   import ftc_pkg::*;

   typedef struct packed {
      logic        is_tree;
      logic [8:0]  reached;
      logic [15:0] edges;
      logic        bad;
   } verdict_type;

   class tree_scoreboard_type;
      logic [8:0]  vcount;
      logic [7:0]  store_a[MaxEdges];
      logic [7:0]  store_b[MaxEdges];
      int unsigned edge_cnt;
      bit          bad_flag;
      verdict_type pending[$];
      int          errors;

      function void clear_graph();
         edge_cnt = 0;
         bad_flag = 0;
      endfunction

      function void note_edge(logic [7:0] a, logic [7:0] b);
         if (a >= vcount || b >= vcount) bad_flag = 1;
         if (edge_cnt < MaxEdges) begin
            store_a[edge_cnt] = a;
            store_b[edge_cnt] = b;
         end
         if (edge_cnt < 65535) edge_cnt++;
      endfunction

      function void note_eval();
         int unsigned nv, stored, depth, reached, v, e, a, b;
         bit marks[MaxVertices];
         int unsigned stk[MaxVertices];
         verdict_type r;
         nv = vcount < MaxVertices ? vcount : MaxVertices;
         stored = edge_cnt < MaxEdges ? edge_cnt : MaxEdges;
         depth = 0;
         reached = 0;
         foreach (marks[i]) marks[i] = 0;
         if (nv > 0) begin
            marks[0] = 1;
            reached = 1;
            stk[0] = 0;
            depth = 1;
         end
         while (depth > 0) begin
            depth--;
            v = stk[depth];
            for (e = 0; e < stored; e++) begin
               a = store_a[e];
               b = store_b[e];
               if (a >= nv || b >= nv) continue;
               if (a == v && !marks[b]) begin
                  marks[b] = 1; reached++; stk[depth] = b; depth++;
               end
               if (b == v && !marks[a]) begin
                  marks[a] = 1; reached++; stk[depth] = a; depth++;
               end
            end
         end
         r.is_tree = nv > 0 && !bad_flag && edge_cnt <= MaxEdges &&
                     edge_cnt == nv - 1 && reached == nv;
         r.reached = reached[8:0];
         r.edges = edge_cnt[15:0];
         r.bad = bad_flag;
         pending.push_back(r);
         clear_graph();
      endfunction

      function void check_result(logic [31:0] d);
         verdict_type exp_r;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, d);
            errors++;
            return;
         end
         exp_r = pending.pop_front();
         if (d[0] !== exp_r.is_tree) begin
            $display("%0t: is_tree expected %0d actual %0d", $time, exp_r.is_tree, d[0]);
            errors++;
         end
         if (d[9:1] !== exp_r.reached) begin
            $display("%0t: reached_count expected %0d actual %0d", $time, exp_r.reached,
                     d[9:1]);
            errors++;
         end
         if (d[25:10] !== exp_r.edges) begin
            $display("%0t: edge_total expected %0d actual %0d", $time, exp_r.edges,
                     d[25:10]);
            errors++;
         end
         if (d[26] !== exp_r.bad) begin
            $display("%0t: bad_endpoint expected %0d actual %0d", $time, exp_r.bad, d[26]);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [8:0]  csr_wdata = '0;

   tree_scoreboard_type sb = new();
   bit   calm = 0;
   longint cycles = 0;

   free_tree_check_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 3000000) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      rsp_tready <= calm || ($urandom_range(99) >= 19);
   end

   task automatic send_item(logic op, logic [7:0] a, logic [7:0] b);
      while (!calm && $urandom_range(99) < 19) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {7'd0, b, a, op};
      do @(posedge clock); while (!req_tready);
      if (op == OpEval) sb.note_eval();
      else sb.note_edge(a, b);
   endtask

   task automatic write_vcount(logic [8:0] v);
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_valid <= 1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      sb.vcount = v;
      csr_valid <= 0;
   endtask

   task automatic send_tree(int n, bit broken);
      int k;
      for (k = 1; k < n; k++)
         send_item(OpAdd, k[7:0], 8'($urandom_range(k - 1)));
      if (broken) send_item(OpAdd, 8'($urandom), 8'($urandom));
      send_item(OpEval, 8'($urandom), 8'($urandom));
   endtask

   initial begin
      int n, items, k;
      sb.vcount = 0;
      sb.errors = 0;
      sb.clear_graph();
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_item(OpEval, 8'hff, 8'hff);
      send_item(OpAdd, 8'h00, 8'h00);
      send_item(OpEval, 8'h00, 8'h00);
      write_vcount(9'd1);
      send_item(OpEval, 8'h00, 8'h00);
      send_item(OpAdd, 8'h00, 8'h00);
      send_item(OpEval, 8'h00, 8'h00);
      write_vcount(9'd2);
      send_item(OpAdd, 8'h01, 8'h00);
      send_item(OpEval, 8'h55, 8'haa);
      send_item(OpAdd, 8'hff, 8'h00);
      send_item(OpEval, 8'h00, 8'h00);
      write_vcount(9'd256);
      send_tree(256, 0);
      write_vcount(9'd511);
      send_item(OpAdd, 8'hff, 8'h00);
      send_item(OpAdd, 8'h00, 8'hff);
      send_item(OpEval, 8'h00, 8'h00);
      write_vcount(9'd3);
      for (k = 0; k < 520; k++) send_item(OpAdd, 8'($urandom_range(2)), 8'($urandom_range(2)));
      send_item(OpEval, 8'h00, 8'h00);
      items = 0;
      while (items < 1200) begin
         calm = (items > 400 && items < 700);
         if ($urandom_range(7) == 0) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(256, 300) : $urandom_range(16);
            write_vcount(9'(n));
         end
         n = sb.vcount < 256 ? sb.vcount : 256;
         if (n > 24) n = $urandom_range(24);
         case ($urandom_range(3))
            0, 1: begin
               send_tree(n, 0);
               items += n;
            end
            2: begin
               send_tree(n, 1);
               items += n + 1;
            end
            default: begin
               for (k = $urandom_range(12); k > 0; k--) begin
                  send_item(OpAdd, 8'($urandom_range(n + 1)), 8'($urandom));
                  items++;
               end
               send_item(OpEval, 8'($urandom), 8'($urandom));
               items++;
            end
         endcase
      end
      calm = 0;
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
`default_nettype wire

>>> sim.f
rtl/ftc_pkg.sv
rtl/ftc_ram.sv
rtl/free_tree_check_core.sv
tb/free_tree_check_core_test.sv
